FILE: rtl/aabb_tpo_pkg.sv
package aabb_tpo_pkg;

   localparam int SLOTS_DEF      = 8;
   localparam int COORD_BITS_DEF = 16;
   localparam int TAG_BITS_DEF   = 16;

   typedef enum logic [1:0] {
      MODE_INSERT = 2'd0,
      MODE_UPDATE = 2'd1,
      MODE_REMOVE = 2'd2,
      MODE_QUERY  = 2'd3
   } mode_type;

   typedef enum logic [1:0] {
      STATUS_OK     = 2'd0,
      STATUS_FULL   = 2'd1,
      STATUS_UNUSED = 2'd2
   } status_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_OP,
      ST_READ,
      ST_CMP,
      ST_FLUSH
   } state_type;

   typedef struct packed {
      logic load_req;
      logic exec_op;
      logic pair_step;
      logic flush;
   } dp_cmd_type;

   typedef struct packed {
      mode_type mode;
      logic     out_free;
      logic     pair_hit;
      logic     pend_valid;
   } dp_stat_type;

endpackage

FILE: rtl/aabb_tpo_if.sv
interface aabb_tpo_req_if;
   logic               valid;
   logic               ready;
   logic [1:0]         mode;
   logic [2:0]         slot_key;
   logic signed [15:0] min_x;
   logic signed [15:0] min_y;
   logic signed [15:0] max_x;
   logic signed [15:0] max_y;
   logic [15:0]        client_data;

   modport source (
      output valid, mode, slot_key, min_x, min_y, max_x, max_y, client_data,
      input  ready
   );
   modport sink (
      input  valid, mode, slot_key, min_x, min_y, max_x, max_y, client_data,
      output ready
   );
endinterface

interface aabb_tpo_rsp_if;
   logic        valid;
   logic        ready;
   logic [2:0]  slot;
   logic [15:0] client_first;
   logic [15:0] client_second;
   logic        pair_valid;
   logic [1:0]  status;
   logic        last;

   modport source (
      output valid, slot, client_first, client_second, pair_valid, status, last,
      input  ready
   );
   modport sink (
      input  valid, slot, client_first, client_second, pair_valid, status, last,
      output ready
   );
endinterface

FILE: rtl/aabb_table_pair_overlap_top.sv
// channel   modport  transaction
// req_ch    sink     one table operation or self query
// rsp_ch    source   one result; last marks the final result of a request
//
// insert, update and remove latch the request, then do one read-modify-write of the table.
// self query runs latch, mode decode, then a read and a compare for each slot pair
// through the registered read of the box and tag memories, plus a final flush
// of the held pair.
// reset clears used flags, free stack depth and high water; box and tag memories keep contents.
// a stalled rsp_ch holds the waiting result and pauses the controller; a new request
// is still taken while the previous result waits.
module aabb_table_pair_overlap_top
   import aabb_tpo_pkg::*;
#(
   parameter int SLOTS      = SLOTS_DEF,
   parameter int COORD_BITS = COORD_BITS_DEF,
   parameter int TAG_BITS   = TAG_BITS_DEF
) (
   input logic            clock,
   input logic            reset,
   aabb_tpo_req_if.sink   req_ch,
   aabb_tpo_rsp_if.source rsp_ch
);

   dp_cmd_type               cmd;
   dp_stat_type              stat;
   logic [$clog2(SLOTS)-1:0] rd_a;
   logic [$clog2(SLOTS)-1:0] rd_b;

   aabb_tpo_ctrl #(
      .SLOTS (SLOTS)
   ) u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_ch.valid),
      .req_ready (req_ch.ready),
      .cmd       (cmd),
      .stat      (stat),
      .rd_a      (rd_a),
      .rd_b      (rd_b)
   );

   aabb_tpo_dp #(
      .SLOTS      (SLOTS),
      .COORD_BITS (COORD_BITS),
      .TAG_BITS   (TAG_BITS)
   ) u_dp (
      .clock             (clock),
      .reset             (reset),
      .cmd               (cmd),
      .stat              (stat),
      .rd_a              (rd_a),
      .rd_b              (rd_b),
      .req_mode          (req_ch.mode),
      .req_slot_key      (req_ch.slot_key),
      .req_min_x         (req_ch.min_x),
      .req_min_y         (req_ch.min_y),
      .req_max_x         (req_ch.max_x),
      .req_max_y         (req_ch.max_y),
      .req_client_data   (req_ch.client_data),
      .rsp_valid         (rsp_ch.valid),
      .rsp_ready         (rsp_ch.ready),
      .rsp_slot          (rsp_ch.slot),
      .rsp_client_first  (rsp_ch.client_first),
      .rsp_client_second (rsp_ch.client_second),
      .rsp_pair_valid    (rsp_ch.pair_valid),
      .rsp_status        (rsp_ch.status),
      .rsp_last          (rsp_ch.last)
   );

endmodule

FILE: rtl/aabb_tpo_ctrl.sv
module aabb_tpo_ctrl
   import aabb_tpo_pkg::*;
#(
   parameter int SLOTS = SLOTS_DEF
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   output logic                     req_ready,
   output dp_cmd_type               cmd,
   input  dp_stat_type              stat,
   output logic [$clog2(SLOTS)-1:0] rd_a,
   output logic [$clog2(SLOTS)-1:0] rd_b
);

   localparam int IW = $clog2(SLOTS);

   state_type        state_ff, state_in;
   logic [IW-1:0]    a_ff, a_in;
   logic [IW-1:0]    b_ff, b_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         a_ff     <= '0;
         b_ff     <= '0;
      end else begin
         state_ff <= state_in;
         a_ff     <= a_in;
         b_ff     <= b_in;
      end
   end

   always_comb begin
      state_in  = state_ff;
      a_in      = a_ff;
      b_in      = b_ff;
      cmd       = '0;
      req_ready = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.load_req = 1'b1;
               a_in         = '0;
               b_in         = IW'(1);
               state_in     = ST_OP;
            end
         end
         ST_OP: begin
            if (stat.mode == MODE_QUERY) begin
               state_in = ST_READ;
            end else if (stat.out_free) begin
               cmd.exec_op = 1'b1;
               state_in    = ST_IDLE;
            end
         end
         ST_READ: begin
            state_in = ST_CMP;
         end
         ST_CMP: begin
            if (!(stat.pair_hit && stat.pend_valid && !stat.out_free)) begin
               cmd.pair_step = 1'b1;
               state_in      = ST_READ;
               if (b_ff == IW'(SLOTS - 1)) begin
                  if (a_ff == IW'(SLOTS - 2)) begin
                     state_in = ST_FLUSH;
                  end else begin
                     a_in = a_ff + IW'(1);
                     b_in = a_ff + IW'(2);
                  end
               end else begin
                  b_in = b_ff + IW'(1);
               end
            end
         end
         ST_FLUSH: begin
            if (stat.out_free) begin
               cmd.flush = 1'b1;
               state_in  = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   assign rd_a = a_ff;
   assign rd_b = b_ff;

   a_exec_room: assert property (@(posedge clock) disable iff (reset)
      cmd.exec_op |-> stat.out_free)
      else $error("operation result loaded over a waiting transaction");

   a_pair_room: assert property (@(posedge clock) disable iff (reset)
      (cmd.pair_step && stat.pair_hit && stat.pend_valid) |-> stat.out_free)
      else $error("pair result loaded over a waiting transaction");

   a_pair_order: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_CMP) |-> (b_ff > a_ff))
      else $error("pair scan left upper triangle");

endmodule

FILE: rtl/aabb_tpo_dp.sv
module aabb_tpo_dp
   import aabb_tpo_pkg::*;
#(
   parameter int SLOTS      = SLOTS_DEF,
   parameter int COORD_BITS = COORD_BITS_DEF,
   parameter int TAG_BITS   = TAG_BITS_DEF
) (
   input  logic                     clock,
   input  logic                     reset,
   input  dp_cmd_type               cmd,
   output dp_stat_type              stat,
   input  logic [$clog2(SLOTS)-1:0] rd_a,
   input  logic [$clog2(SLOTS)-1:0] rd_b,
   input  logic [1:0]               req_mode,
   input  logic [2:0]               req_slot_key,
   input  logic signed [15:0]       req_min_x,
   input  logic signed [15:0]       req_min_y,
   input  logic signed [15:0]       req_max_x,
   input  logic signed [15:0]       req_max_y,
   input  logic [15:0]              req_client_data,
   output logic                     rsp_valid,
   input  logic                     rsp_ready,
   output logic [2:0]               rsp_slot,
   output logic [15:0]              rsp_client_first,
   output logic [15:0]              rsp_client_second,
   output logic                     rsp_pair_valid,
   output logic [1:0]               rsp_status,
   output logic                     rsp_last
);

   localparam int IW = $clog2(SLOTS);
   localparam int NW = $clog2(SLOTS + 1);
   localparam int CW = COORD_BITS;
   localparam int BW = 4 * COORD_BITS;
   localparam int TW = TAG_BITS;

   function automatic logic boxes_overlap(input logic [BW-1:0] a, input logic [BW-1:0] b);
      logic signed [CW-1:0] a_lx, a_ly, a_hx, a_hy, b_lx, b_ly, b_hx, b_hy;
      a_lx = $signed(a[CW-1:0]);
      a_ly = $signed(a[2*CW-1:CW]);
      a_hx = $signed(a[3*CW-1:2*CW]);
      a_hy = $signed(a[4*CW-1:3*CW]);
      b_lx = $signed(b[CW-1:0]);
      b_ly = $signed(b[2*CW-1:CW]);
      b_hx = $signed(b[3*CW-1:2*CW]);
      b_hy = $signed(b[4*CW-1:3*CW]);
      return (a_lx <= b_hx) && (b_lx <= a_hx) && (a_ly <= b_hy) && (b_ly <= a_hy);
   endfunction

   // latched transaction
   mode_type         mode_ff;
   logic [2:0]       key_ff;
   logic [BW-1:0]    box_ff;
   logic [TW-1:0]    tag_ff;

   // table state
   logic [BW-1:0]    box_mem [SLOTS];
   logic [TW-1:0]    tag_mem [SLOTS];
   logic [BW-1:0]    rd_box_a_ff, rd_box_b_ff;
   logic [TW-1:0]    rd_tag_a_ff, rd_tag_b_ff;
   logic [SLOTS-1:0] used_ff, used_in;
   logic [IW-1:0]    stack_ff [SLOTS];
   logic [NW-1:0]    free_ff, free_in;
   logic [NW-1:0]    hw_ff, hw_in;

   // held pair and output register
   logic             pend_valid_ff, pend_valid_in;
   logic [15:0]      pend_first_ff, pend_second_ff;
   logic             rsp_valid_ff, rsp_valid_in;
   logic [2:0]       rsp_slot_ff, rsp_slot_in;
   logic [15:0]      rsp_first_ff, rsp_first_in;
   logic [15:0]      rsp_second_ff, rsp_second_in;
   logic             rsp_pair_ff, rsp_pair_in;
   status_type       rsp_status_ff, rsp_status_in;
   logic             rsp_last_ff, rsp_last_in;

   // conversions
   logic [CW+15:0]   lx_wide, ly_wide, hx_wide, hy_wide;
   logic [TW+15:0]   tag_in_wide;
   logic [TW+15:0]   tag_a_wide, tag_b_wide;
   logic [IW+2:0]    key_wide;
   logic [IW-1:0]    key_idx;
   logic             key_ok;
   logic [NW-1:0]    free_dec;
   logic [IW-1:0]    ins_idx;
   logic [IW+2:0]    ins_wide;
   logic             ins_stack, ins_fresh;

   logic             box_we, tag_we, push, pend_load, rsp_load, pair_hit;
   logic [IW-1:0]    wr_idx;

   assign lx_wide     = {{CW{req_min_x[15]}}, req_min_x};
   assign ly_wide     = {{CW{req_min_y[15]}}, req_min_y};
   assign hx_wide     = {{CW{req_max_x[15]}}, req_max_x};
   assign hy_wide     = {{CW{req_max_y[15]}}, req_max_y};
   assign tag_in_wide = {{TW{1'b0}}, req_client_data};
   assign tag_a_wide  = {16'b0, rd_tag_a_ff};
   assign tag_b_wide  = {16'b0, rd_tag_b_ff};

   assign key_wide  = {{IW{1'b0}}, key_ff};
   assign key_idx   = key_wide[IW-1:0];
   assign key_ok    = (32'(key_ff) < 32'(SLOTS)) && used_ff[key_idx];
   assign free_dec  = free_ff - NW'(1);
   assign ins_stack = (free_ff != '0);
   assign ins_fresh = (hw_ff < NW'(SLOTS));
   assign ins_idx   = ins_stack ? stack_ff[free_dec[IW-1:0]] : hw_ff[IW-1:0];
   assign ins_wide  = {3'b0, ins_idx};

   assign pair_hit = used_ff[rd_a] && used_ff[rd_b] && boxes_overlap(rd_box_a_ff, rd_box_b_ff);

   always_comb begin
      used_in       = used_ff;
      free_in       = free_ff;
      hw_in         = hw_ff;
      push          = 1'b0;
      box_we        = 1'b0;
      tag_we        = 1'b0;
      wr_idx        = key_idx;
      pend_load     = 1'b0;
      pend_valid_in = pend_valid_ff;
      rsp_load      = 1'b0;
      rsp_slot_in   = rsp_slot_ff;
      rsp_first_in  = rsp_first_ff;
      rsp_second_in = rsp_second_ff;
      rsp_pair_in   = rsp_pair_ff;
      rsp_status_in = rsp_status_ff;
      rsp_last_in   = rsp_last_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_ready;

      if (cmd.exec_op) begin
         rsp_load      = 1'b1;
         rsp_first_in  = '0;
         rsp_second_in = '0;
         rsp_pair_in   = 1'b0;
         rsp_last_in   = 1'b1;
         rsp_status_in = STATUS_OK;
         rsp_slot_in   = key_ff;
         case (mode_ff) inside
            MODE_INSERT: begin
               if (ins_stack || ins_fresh) begin
                  if (ins_stack) begin
                     free_in = free_dec;
                  end else begin
                     hw_in = hw_ff + NW'(1);
                  end
                  used_in[ins_idx] = 1'b1;
                  box_we           = 1'b1;
                  tag_we           = 1'b1;
                  wr_idx           = ins_idx;
                  rsp_slot_in      = ins_wide[2:0];
               end else begin
                  rsp_slot_in   = '0;
                  rsp_status_in = STATUS_FULL;
               end
            end
            MODE_UPDATE, MODE_REMOVE: begin
               if (!key_ok) begin
                  rsp_status_in = STATUS_UNUSED;
               end else if (mode_ff == MODE_UPDATE) begin
                  box_we = 1'b1;
               end else begin
                  used_in[key_idx] = 1'b0;
                  push             = 1'b1;
                  free_in          = free_ff + NW'(1);
               end
            end
            default: begin
               rsp_load = 1'b0;
            end
         endcase
      end

      if (cmd.pair_step && pair_hit) begin
         pend_load     = 1'b1;
         pend_valid_in = 1'b1;
         if (pend_valid_ff) begin
            rsp_load      = 1'b1;
            rsp_slot_in   = '0;
            rsp_first_in  = pend_first_ff;
            rsp_second_in = pend_second_ff;
            rsp_pair_in   = 1'b1;
            rsp_status_in = STATUS_OK;
            rsp_last_in   = 1'b0;
         end
      end

      if (cmd.flush) begin
         rsp_load      = 1'b1;
         pend_valid_in = 1'b0;
         rsp_slot_in   = '0;
         rsp_status_in = STATUS_OK;
         rsp_last_in   = 1'b1;
         rsp_pair_in   = pend_valid_ff;
         rsp_first_in  = pend_valid_ff ? pend_first_ff : 16'b0;
         rsp_second_in = pend_valid_ff ? pend_second_ff : 16'b0;
      end

      if (rsp_load) begin
         rsp_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (box_we) begin
         box_mem[wr_idx] <= box_ff;
      end
      if (tag_we) begin
         tag_mem[wr_idx] <= tag_ff;
      end
      rd_box_a_ff <= box_mem[rd_a];
      rd_box_b_ff <= box_mem[rd_b];
      rd_tag_a_ff <= tag_mem[rd_a];
      rd_tag_b_ff <= tag_mem[rd_b];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         used_ff       <= '0;
         free_ff       <= '0;
         hw_ff         <= '0;
         pend_valid_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         used_ff       <= used_in;
         free_ff       <= free_in;
         hw_ff         <= hw_in;
         pend_valid_ff <= pend_valid_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load_req) begin
         mode_ff <= mode_type'(req_mode);
         key_ff  <= req_slot_key;
         box_ff  <= {hy_wide[CW-1:0], hx_wide[CW-1:0], ly_wide[CW-1:0], lx_wide[CW-1:0]};
         tag_ff  <= tag_in_wide[TW-1:0];
      end
      if (push) begin
         stack_ff[free_ff[IW-1:0]] <= key_idx;
      end
      if (pend_load) begin
         pend_first_ff  <= tag_a_wide[15:0];
         pend_second_ff <= tag_b_wide[15:0];
      end
      rsp_slot_ff   <= rsp_slot_in;
      rsp_first_ff  <= rsp_first_in;
      rsp_second_ff <= rsp_second_in;
      rsp_pair_ff   <= rsp_pair_in;
      rsp_status_ff <= rsp_status_in;
      rsp_last_ff   <= rsp_last_in;
   end

   assign stat.mode       = mode_ff;
   assign stat.out_free   = !rsp_valid_ff || rsp_ready;
   assign stat.pair_hit   = pair_hit;
   assign stat.pend_valid = pend_valid_ff;

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_slot          = rsp_slot_ff;
   assign rsp_client_first  = rsp_first_ff;
   assign rsp_client_second = rsp_second_ff;
   assign rsp_pair_valid    = rsp_pair_ff;
   assign rsp_status        = rsp_status_ff;
   assign rsp_last          = rsp_last_ff;

   a_slot_count: assert property (@(posedge clock) disable iff (reset)
      $countones(used_ff) == (32'(hw_ff) - 32'(free_ff)))
      else $error("used slots disagree with high water and free stack");

   a_free_bound: assert property (@(posedge clock) disable iff (reset)
      (free_ff <= hw_ff) && (hw_ff <= NW'(SLOTS)))
      else $error("free stack or high water out of range");

   a_pend_clear: assert property (@(posedge clock) disable iff (reset)
      cmd.flush |=> !pend_valid_ff)
      else $error("held pair survived the end of a query");

endmodule

FILE: test/tb_aabb_table_pair_overlap_top.sv
module tb_aabb_table_pair_overlap_top;
   import aabb_tpo_pkg::*;

   localparam int CLOCK_HALF   = 5;
   localparam int SETTLE_TICKS = 64;
   localparam int DRAIN_CAP    = 20000;

   typedef struct packed {
      logic signed [15:0] lx;
      logic signed [15:0] ly;
      logic signed [15:0] hx;
      logic signed [15:0] hy;
   } box_t;

   typedef struct packed {
      logic [2:0]  slot;
      logic [15:0] first;
      logic [15:0] second;
      logic        pair;
      logic [1:0]  status;
      logic        last;
   } result_t;

   logic clock = 1'b0;
   logic reset;

   aabb_tpo_req_if req_ch ();
   aabb_tpo_rsp_if rsp_ch ();

   aabb_table_pair_overlap_top u_dut (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch),
      .rsp_ch (rsp_ch)
   );

   always begin
      #CLOCK_HALF clock = 1'b1;
      #CLOCK_HALF clock = 1'b0;
   end

   // shadow copy of the box table
   box_t        shadow_box [SLOTS_DEF];
   logic [15:0] shadow_tag [SLOTS_DEF];
   logic        shadow_used [SLOTS_DEF];
   logic [2:0]  shadow_stack [SLOTS_DEF];
   int          shadow_free_cnt;
   int          shadow_high;

   result_t results_due [$];

   int mismatches;
   int requests_taken;
   int results_seen;
   int queries_taken;
   int pairs_seen;
   int send_idle_pct;
   int sink_idle_pct;
   int stall_left;

   function automatic box_t make_box(input int lx, input int ly, input int hx, input int hy);
      box_t b;
      b.lx = 16'(lx);
      b.ly = 16'(ly);
      b.hx = 16'(hx);
      b.hy = 16'(hy);
      return b;
   endfunction

   function automatic logic boxes_touch(input box_t a, input box_t b);
      return (a.lx <= b.hx) && (b.lx <= a.hx) && (a.ly <= b.hy) && (b.ly <= a.hy);
   endfunction

   function automatic void push_result(input logic [2:0] slot, input logic [15:0] first,
                                       input logic [15:0] second, input logic pair,
                                       input status_type status, input logic last);
      result_t r;
      r.slot   = slot;
      r.first  = first;
      r.second = second;
      r.pair   = pair;
      r.status = status;
      r.last   = last;
      results_due.push_back(r);
   endfunction

   function automatic void apply_to_shadow(input mode_type m, input logic [2:0] key,
                                           input box_t b, input logic [15:0] tag);
      int s;
      int n;
      case (m)
         MODE_INSERT: begin
            if (shadow_free_cnt > 0) begin
               shadow_free_cnt--;
               s = shadow_stack[shadow_free_cnt];
            end else if (shadow_high < SLOTS_DEF) begin
               s = shadow_high;
               shadow_high++;
            end else begin
               push_result(3'd0, 16'd0, 16'd0, 1'b0, STATUS_FULL, 1'b1);
               return;
            end
            shadow_used[s] = 1'b1;
            shadow_box[s]  = b;
            shadow_tag[s]  = tag;
            push_result(3'(s), 16'd0, 16'd0, 1'b0, STATUS_OK, 1'b1);
         end
         MODE_UPDATE, MODE_REMOVE: begin
            if (int'(key) >= SLOTS_DEF || !shadow_used[key]) begin
               push_result(key, 16'd0, 16'd0, 1'b0, STATUS_UNUSED, 1'b1);
               return;
            end
            if (m == MODE_UPDATE) begin
               shadow_box[key] = b;
            end else begin
               shadow_used[key] = 1'b0;
               if (shadow_free_cnt < SLOTS_DEF) begin
                  shadow_stack[shadow_free_cnt] = key;
                  shadow_free_cnt++;
               end
            end
            push_result(key, 16'd0, 16'd0, 1'b0, STATUS_OK, 1'b1);
         end
         default: begin
            n = 0;
            for (int i = 0; i < SLOTS_DEF; i++) begin
               if (!shadow_used[i]) continue;
               for (int j = i + 1; j < SLOTS_DEF; j++) begin
                  if (shadow_used[j] && boxes_touch(shadow_box[i], shadow_box[j])) begin
                     push_result(3'd0, shadow_tag[i], shadow_tag[j], 1'b1, STATUS_OK, 1'b0);
                     n++;
                  end
               end
            end
            if (n == 0) push_result(3'd0, 16'd0, 16'd0, 1'b0, STATUS_OK, 1'b1);
            else results_due[results_due.size() - 1].last = 1'b1;
         end
      endcase
   endfunction

   function automatic void check_field(input string name, input int unsigned want,
                                       input int unsigned got);
      if (want != got) begin
         $error("%s mismatch: expected %0d, got %0d", name, want, got);
         mismatches++;
      end
   endfunction

   // results are checked before the request of the same edge is applied
   always @(posedge clock) begin : monitor
      result_t want;
      box_t    b;
      if (!reset) begin
         if (rsp_ch.valid && rsp_ch.ready) begin
            results_seen++;
            if (results_due.size() == 0) begin
               $error("result with nothing outstanding: slot %0d status %0d pair %0d",
                      rsp_ch.slot, rsp_ch.status, rsp_ch.pair_valid);
               mismatches++;
            end else begin
               want = results_due.pop_front();
               if (rsp_ch.pair_valid) pairs_seen++;
               check_field("slot", want.slot, rsp_ch.slot);
               check_field("client_first", want.first, rsp_ch.client_first);
               check_field("client_second", want.second, rsp_ch.client_second);
               check_field("pair_valid", want.pair, rsp_ch.pair_valid);
               check_field("status", want.status, rsp_ch.status);
               check_field("last", want.last, rsp_ch.last);
            end
         end
         if (req_ch.valid && req_ch.ready) begin
            requests_taken++;
            if (mode_type'(req_ch.mode) == MODE_QUERY) queries_taken++;
            b.lx = req_ch.min_x;
            b.ly = req_ch.min_y;
            b.hx = req_ch.max_x;
            b.hy = req_ch.max_y;
            apply_to_shadow(mode_type'(req_ch.mode), req_ch.slot_key, b, req_ch.client_data);
         end
      end
   end

   // result side back-pressure in random bursts
   always @(negedge clock) begin
      if (stall_left > 0) begin
         rsp_ch.ready <= 1'b0;
         stall_left   <= stall_left - 1;
      end else if (sink_idle_pct != 0 && $urandom_range(0, 99) < sink_idle_pct) begin
         rsp_ch.ready <= 1'b0;
         stall_left   <= $urandom_range(0, 14);
      end else begin
         rsp_ch.ready <= 1'b1;
      end
   end

   task automatic send_op(input mode_type m, input logic [2:0] key, input box_t b,
                          input logic [15:0] tag);
      int gap;
      gap = 0;
      if (send_idle_pct != 0 && $urandom_range(0, 99) < send_idle_pct)
         gap = $urandom_range(1, 15);
      @(negedge clock);
      if (gap != 0) begin
         req_ch.valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_ch.valid       <= 1'b1;
      req_ch.mode        <= m;
      req_ch.slot_key    <= key;
      req_ch.min_x       <= b.lx;
      req_ch.min_y       <= b.ly;
      req_ch.max_x       <= b.hx;
      req_ch.max_y       <= b.hy;
      req_ch.client_data <= tag;
      do @(posedge clock); while (!req_ch.ready);
   endtask

   task automatic wait_for_results();
      int cycles;
      cycles = 0;
      @(negedge clock);
      req_ch.valid <= 1'b0;
      while (results_due.size() != 0 && cycles < DRAIN_CAP) begin
         @(posedge clock);
         cycles++;
      end
   endtask

   function automatic box_t random_box();
      box_t b;
      int   cx;
      int   cy;
      cx = int'($urandom_range(0, 600)) - 300;
      cy = int'($urandom_range(0, 600)) - 300;
      case ($urandom_range(0, 9))
         0: begin
            b.lx = 16'($urandom());
            b.ly = 16'($urandom());
            b.hx = 16'($urandom());
            b.hy = 16'($urandom());
         end
         1: b = make_box(cx + int'($urandom_range(1, 80)), cy + int'($urandom_range(1, 80)),
                         cx, cy);
         default: b = make_box(cx, cy, cx + int'($urandom_range(0, 150)),
                               cy + int'($urandom_range(0, 150)));
      endcase
      return b;
   endfunction

   function automatic logic [2:0] pick_slot();
      int live [$];
      for (int i = 0; i < SLOTS_DEF; i++) if (shadow_used[i]) live.push_back(i);
      if (live.size() == 0 || $urandom_range(0, 99) < 20) return 3'($urandom_range(0, 7));
      return 3'(live[$urandom_range(0, live.size() - 1)]);
   endfunction

   // mostly real slot traffic, some stale or random keys
   task automatic send_random_op();
      int       r;
      mode_type m;
      r = $urandom_range(0, 99);
      if (r < 35)      m = MODE_INSERT;
      else if (r < 55) m = MODE_UPDATE;
      else if (r < 80) m = MODE_REMOVE;
      else             m = MODE_QUERY;
      if (m == MODE_UPDATE || m == MODE_REMOVE)
         send_op(m, pick_slot(), random_box(), 16'($urandom()));
      else
         send_op(m, 3'($urandom_range(0, 7)), random_box(), 16'($urandom()));
   endtask

   task automatic test_empty_table();
      send_op(MODE_QUERY, 3'd0, make_box(0, 0, 0, 0), 16'd0);
   endtask

   task automatic test_unused_slots();
      send_op(MODE_UPDATE, 3'd7, make_box(1, 1, 2, 2), 16'hFFFF);
      send_op(MODE_REMOVE, 3'd0, make_box(0, 0, 0, 0), 16'd0);
   endtask

   task automatic test_fill_and_full();
      logic [15:0] tags [SLOTS_DEF];
      tags = '{16'h0000, 16'hFFFF, 16'h1234, 16'h8001, 16'h7FFE, 16'h00FF, 16'hFF00, 16'h5A5A};
      for (int i = 0; i < SLOTS_DEF; i++)
         send_op(MODE_INSERT, 3'(i), make_box(-32768, -32768, 32767, 32767), tags[i]);
      send_op(MODE_INSERT, 3'd0, make_box(0, 0, 0, 0), 16'hAAAA);
      send_op(MODE_QUERY, 3'd0, make_box(0, 0, 0, 0), 16'd0);
   endtask

   task automatic test_edge_boxes();
      send_op(MODE_UPDATE, 3'd3, make_box(100, 100, -100, -100), 16'd0);
      send_op(MODE_UPDATE, 3'd5, make_box(32767, 32767, 32767, 32767), 16'd0);
      send_op(MODE_UPDATE, 3'd6, make_box(-32768, -32768, -32768, -32768), 16'd0);
      send_op(MODE_UPDATE, 3'd1, make_box(0, 0, 10, 10), 16'd0);
      send_op(MODE_QUERY, 3'd7, make_box(0, 0, 0, 0), 16'd0);
   endtask

   task automatic test_free_stack_reuse();
      send_op(MODE_REMOVE, 3'd2, make_box(0, 0, 0, 0), 16'd0);
      send_op(MODE_REMOVE, 3'd5, make_box(0, 0, 0, 0), 16'd0);
      send_op(MODE_REMOVE, 3'd5, make_box(0, 0, 0, 0), 16'd0);
      send_op(MODE_INSERT, 3'd0, make_box(-5, -5, 5, 5), 16'hBEEF);
      send_op(MODE_INSERT, 3'd0, make_box(20, 20, 30, 30), 16'hCAFE);
      send_op(MODE_INSERT, 3'd0, make_box(0, 0, 1, 1), 16'h0001);
      send_op(MODE_QUERY, 3'd0, make_box(0, 0, 0, 0), 16'd0);
   endtask

   task automatic test_random_traffic(input int count);
      for (int k = 0; k < count; k++) begin
         if (k % 40 == 0) begin
            case ($urandom_range(0, 3))
               0: begin send_idle_pct = 0;  sink_idle_pct = 0;  end
               1: begin send_idle_pct = 15; sink_idle_pct = 10; end
               2: begin send_idle_pct = 40; sink_idle_pct = 5;  end
               default: begin send_idle_pct = 5; sink_idle_pct = 40; end
            endcase
         end
         send_random_op();
      end
   endtask

   task automatic test_drain_pause();
      send_idle_pct = 10;
      sink_idle_pct = 30;
      for (int k = 0; k < 20; k++) send_random_op();
      wait_for_results();
      for (int k = 0; k < 20; k++) send_random_op();
   endtask

   task automatic test_back_to_back(input int count);
      send_idle_pct = 0;
      sink_idle_pct = 0;
      for (int k = 0; k < count; k++) send_random_op();
   endtask

   initial begin
      reset              = 1'b1;
      req_ch.valid       = 1'b0;
      req_ch.mode        = MODE_INSERT;
      req_ch.slot_key    = 3'd0;
      req_ch.min_x       = 16'sd0;
      req_ch.min_y       = 16'sd0;
      req_ch.max_x       = 16'sd0;
      req_ch.max_y       = 16'sd0;
      req_ch.client_data = 16'd0;
      rsp_ch.ready       = 1'b0;
      stall_left         = 0;
      send_idle_pct      = 20;
      sink_idle_pct      = 20;
      mismatches         = 0;
      requests_taken     = 0;
      results_seen       = 0;
      queries_taken      = 0;
      pairs_seen         = 0;
      shadow_free_cnt    = 0;
      shadow_high        = 0;
      for (int i = 0; i < SLOTS_DEF; i++) shadow_used[i] = 1'b0;
      repeat (11) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      test_empty_table();
      test_unused_slots();
      test_fill_and_full();
      test_edge_boxes();
      test_free_stack_reuse();
      wait_for_results();
      test_random_traffic(280);
      test_drain_pause();
      test_back_to_back(80);

      wait_for_results();
      repeat (SETTLE_TICKS) @(posedge clock);
      if (results_due.size() != 0) begin
         $error("%0d expected results never arrived", results_due.size());
         mismatches++;
      end
      $display("covered %0d requests (%0d self queries), %0d results checked",
               requests_taken, queries_taken, results_seen);
      $display("overlapping pairs reported: %0d, mismatches: %0d", pairs_seen, mismatches);
      if (mismatches == 0) begin
         $display("Verification passed");
      end else begin
         $display("Verification failed");
      end
      $finish;
   end

   initial begin
      #(CLOCK_HALF * 2 * 1000000);
      $display("Verification failed");
      $finish;
   end

endmodule
